[design/i2cts_pkg.sv]
// ============================================================================
// i2cts_pkg
// Shared types and codes for the I2C target byte sequencer.
// ============================================================================
package i2cts_pkg;

  // Event codes on the mode field of an input item.
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_SHIFT = 2'd1,
    MODE_PUSH  = 2'd2,
    MODE_POP   = 2'd3
  } mode_t;

  // Classified command kinds passed from the front to the back.
  typedef enum logic [2:0] {
    CMD_START = 3'd0,
    CMD_STOP  = 3'd1,
    CMD_SHIFT = 3'd2,
    CMD_PUSH  = 3'd3,
    CMD_POP   = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  // Bus phase of the target.
  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_CHECK_ADDRESS = 3'd1,
    PH_SEND_DATA     = 3'd2,
    PH_REQUEST_REPLY = 3'd3,
    PH_CHECK_REPLY   = 3'd4,
    PH_REQUEST_DATA  = 3'd5,
    PH_GET_DATA      = 3'd6
  } phase_t;

  // Next action of the shifter.
  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_ACK        = 3'd1,
    ACT_RECEIVE    = 3'd2,
    ACT_TRANSMIT   = 3'd3,
    ACT_SAMPLE_ACK = 3'd4,
    ACT_RELEASE    = 3'd5,
    ACT_HOST       = 3'd6
  } action_t;

  // Source of the result byte.
  typedef enum logic [1:0] {
    SEL_NONE = 2'd0,
    SEL_TX   = 2'd1,
    SEL_RX   = 2'd2
  } byte_sel_t;

  // Bit position of the read/write flag in the address byte.
  localparam int ADDR_RW_BIT = 0;

endpackage

[design/i2cts_if.sv]
// ============================================================================
// i2cts interfaces
// Valid/ready channels for events, results and the address register write.
// ============================================================================
interface i2cts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] data;
  logic       stop_seen;

  modport source (output valid, mode, data, stop_seen, input ready);
  modport sink   (input valid, mode, data, stop_seen, output ready);
endinterface

interface i2cts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] out_byte;
  logic [3:0] rx_count;
  logic       overrun;
  logic       host_error;

  modport source (output valid, action, out_byte, rx_count, overrun, host_error,
                  input ready);
  modport sink   (input valid, action, out_byte, rx_count, overrun, host_error,
                  output ready);
endinterface

interface i2cts_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[design/i2c_target_byte_sequencer.sv]
// ============================================================================
// i2c_target_byte_sequencer
// Byte-level I2C target sequencer with receive and transmit rings.
// ============================================================================
//
//  channel  role    payload                                      handshake
//  -------  ------  -------------------------------------------  -----------
//  evt      sink    mode, data, stop_seen                        valid/ready
//  res      source  action, out_byte, rx_count, overrun,         valid/ready
//                   host_error
//  cfg      sink    data (own seven-bit address)                 valid/ready
//
//  One item per cycle sustained while results are taken: the back end runs
//  the phase machine and a ring step together for each command, and each
//  item passes through the queue and then the result register before its
//  result can be accepted.
//  Reset clears the phase, all ring indices and the own address; ring
//  contents are left as they are.
//  A stalled result holds the back end; the two-entry queue keeps taking
//  items until it is full. The cfg port is always ready.
//
module i2c_target_byte_sequencer #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2cts_in_if.sink    evt,
  i2cts_out_if.source res,
  i2cts_cfg_if.sink   cfg
);
  import i2cts_pkg::*;

  logic       cmd_valid;
  logic       cmd_ready;
  cmd_t       cmd;
  logic [6:0] own_address;

  // The user must change the address register only while idle; the block
  // does not enforce this, and the back end reads it without any hold-off.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 7'd0;
    end else if (cfg.valid && cfg.ready) begin
      own_address <= cfg.data;
    end
  end

  // The front end turns each event item into a command and queues it.
  i2cts_front u_front (
    .clk       (clk),
    .rst       (rst),
    .evt       (evt),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_ready (cmd_ready)
  );

  // The back end owns the phase machine, both rings and the result register.
  i2cts_back #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_ready   (cmd_ready),
    .own_address (own_address),
    .res         (res)
  );

endmodule

[design/i2cts_front.sv]
// ============================================================================
// i2cts_front
// Accepts event items, classifies them and holds them in a two-entry queue.
// ============================================================================
module i2cts_front (
  input  logic               clk,
  input  logic               rst,
  i2cts_in_if.sink           evt,
  output logic               cmd_valid,
  output i2cts_pkg::cmd_t    cmd,
  input  logic               cmd_ready
);
  import i2cts_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // A start item carrying the stop flag becomes its own command kind.
  always_comb begin
    cmd_in.data = evt.data;
    unique case (mode_t'(evt.mode))
      MODE_START: cmd_in.kind = evt.stop_seen ? CMD_STOP : CMD_START;
      MODE_SHIFT: cmd_in.kind = CMD_SHIFT;
      MODE_PUSH:  cmd_in.kind = CMD_PUSH;
      MODE_POP:   cmd_in.kind = CMD_POP;
      default:    cmd_in.kind = CMD_POP;
    endcase
  end

  assign evt.ready = (count != 2'd2);
  assign push      = evt.valid && evt.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

endmodule

[design/i2cts_back.sv]
// ============================================================================
// i2cts_back
// Runs the phase machine and both rings into a registered result stage,
// one command per cycle while the result stage is not stalled.
// ============================================================================
module i2cts_back #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  i2cts_pkg::cmd_t cmd,
  output logic            cmd_ready,
  input  logic [6:0]      own_address,
  i2cts_out_if.source     res
);
  import i2cts_pkg::*;

  localparam int RIW = $clog2(RX_DEPTH);
  localparam int TIW = $clog2(TX_DEPTH);
  localparam int FW  = (RIW + 1 > 4) ? RIW + 1 : 4;

  function automatic logic [RIW-1:0] rx_bump(input logic [RIW-1:0] idx);
    return (idx == RIW'(RX_DEPTH - 1)) ? '0 : idx + RIW'(1);
  endfunction

  function automatic logic [TIW-1:0] tx_bump(input logic [TIW-1:0] idx);
    return (idx == TIW'(TX_DEPTH - 1)) ? '0 : idx + TIW'(1);
  endfunction

  logic [7:0]     rx_mem [RX_DEPTH];
  logic [7:0]     tx_mem [TX_DEPTH];

  phase_t         phase;
  phase_t         phase_next;
  logic [RIW-1:0] rx_wr;
  logic [RIW-1:0] rx_wr_next;
  logic [RIW-1:0] rx_rd;
  logic [RIW-1:0] rx_rd_next;
  logic [TIW-1:0] tx_wr;
  logic [TIW-1:0] tx_wr_next;
  logic [TIW-1:0] tx_rd;
  logic [TIW-1:0] tx_rd_next;

  logic           exec;
  logic           addr_hit;
  logic           tx_avail;
  logic           rx_avail;
  logic [RIW-1:0] rx_slot;
  logic [TIW-1:0] tx_slot;
  logic           rx_we;
  logic           tx_we;
  action_t        act;
  byte_sel_t      sel;
  logic           ovr;
  logic           herr;
  logic [FW-1:0]  fill;

  // Result stage.
  logic           out_valid;
  action_t        act_q;
  byte_sel_t      sel_q;
  logic [3:0]     rx_count_q;
  logic           ovr_q;
  logic           herr_q;
  logic [7:0]     tx_rdata;
  logic [7:0]     rx_rdata;

  assign cmd_ready = !out_valid || res.ready;
  assign exec      = cmd_valid && cmd_ready;
  assign addr_hit  = (cmd.data == 8'd0) || (cmd.data[7:1] == own_address);
  assign tx_avail  = (tx_wr != tx_rd);
  assign rx_avail  = (rx_wr != rx_rd);
  assign rx_slot   = rx_bump(rx_wr);
  assign tx_slot   = tx_bump(tx_wr);

  // Next phase.
  always_comb begin
    phase_next = phase;
    unique case (cmd.kind)
      CMD_STOP:  phase_next = PH_IDLE;
      CMD_START: phase_next = PH_CHECK_ADDRESS;
      CMD_SHIFT: begin
        unique case (phase)
          PH_CHECK_ADDRESS: begin
            if (!addr_hit) begin
              phase_next = PH_IDLE;
            end else if (cmd.data[ADDR_RW_BIT]) begin
              phase_next = PH_SEND_DATA;
            end else begin
              phase_next = PH_REQUEST_DATA;
            end
          end
          PH_CHECK_REPLY: begin
            phase_next = (cmd.data == 8'd0 && tx_avail) ? PH_REQUEST_REPLY : PH_IDLE;
          end
          PH_SEND_DATA:     phase_next = tx_avail ? PH_REQUEST_REPLY : PH_IDLE;
          PH_REQUEST_REPLY: phase_next = PH_CHECK_REPLY;
          PH_REQUEST_DATA:  phase_next = PH_GET_DATA;
          PH_GET_DATA:      phase_next = PH_REQUEST_DATA;
          default:          phase_next = PH_IDLE;
        endcase
      end
      default: phase_next = phase;
    endcase
  end

  // Action, ring moves and flags.
  always_comb begin
    act        = ACT_NONE;
    sel        = SEL_NONE;
    ovr        = 1'b0;
    herr       = 1'b0;
    rx_we      = 1'b0;
    tx_we      = 1'b0;
    rx_wr_next = rx_wr;
    rx_rd_next = rx_rd;
    tx_wr_next = tx_wr;
    tx_rd_next = tx_rd;
    unique case (cmd.kind)
      CMD_STOP:  act = ACT_RELEASE;
      CMD_START: act = ACT_RECEIVE;
      CMD_SHIFT: begin
        unique case (phase)
          PH_CHECK_ADDRESS: act = addr_hit ? ACT_ACK : ACT_RELEASE;
          PH_CHECK_REPLY, PH_SEND_DATA: begin
            if ((phase == PH_SEND_DATA || cmd.data == 8'd0) && tx_avail) begin
              act        = ACT_TRANSMIT;
              sel        = SEL_TX;
              tx_rd_next = tx_bump(tx_rd);
            end else begin
              act = ACT_RELEASE;
            end
          end
          PH_REQUEST_REPLY: act = ACT_SAMPLE_ACK;
          PH_REQUEST_DATA:  act = ACT_RECEIVE;
          PH_GET_DATA: begin
            act = ACT_ACK;
            if (rx_slot == rx_rd) begin
              ovr = 1'b1;
            end else begin
              rx_we      = 1'b1;
              rx_wr_next = rx_slot;
            end
          end
          default: act = ACT_NONE;
        endcase
      end
      CMD_PUSH: begin
        if (tx_slot == tx_rd) begin
          herr = 1'b1;
        end else begin
          tx_we      = 1'b1;
          tx_wr_next = tx_slot;
        end
      end
      CMD_POP: begin
        act = ACT_HOST;
        if (!rx_avail) begin
          herr = 1'b1;
        end else begin
          sel        = SEL_RX;
          rx_rd_next = rx_bump(rx_rd);
        end
      end
      default: act = ACT_NONE;
    endcase
  end

  // Receive ring occupancy after this command.
  always_comb begin
    if (rx_wr_next >= rx_rd_next) begin
      fill = FW'(rx_wr_next) - FW'(rx_rd_next);
    end else begin
      fill = FW'(rx_wr_next) + FW'(RX_DEPTH) - FW'(rx_rd_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_IDLE;
      rx_wr     <= '0;
      rx_rd     <= '0;
      tx_wr     <= '0;
      tx_rd     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (exec) begin
        phase <= phase_next;
        rx_wr <= rx_wr_next;
        rx_rd <= rx_rd_next;
        tx_wr <= tx_wr_next;
        tx_rd <= tx_rd_next;
      end
      if (exec) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Ring storage; read data lands in the result stage.
  always_ff @(posedge clk) begin
    if (exec && rx_we) begin
      rx_mem[rx_slot] <= cmd.data;
    end
    if (exec && tx_we) begin
      tx_mem[tx_slot] <= cmd.data;
    end
    if (exec && sel == SEL_RX) begin
      rx_rdata <= rx_mem[rx_rd_next];
    end
    if (exec && sel == SEL_TX) begin
      tx_rdata <= tx_mem[tx_rd_next];
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      act_q      <= act;
      sel_q      <= sel;
      rx_count_q <= fill[3:0];
      ovr_q      <= ovr;
      herr_q     <= herr;
    end
  end

  always_comb begin
    unique case (sel_q)
      SEL_TX:  res.out_byte = tx_rdata;
      SEL_RX:  res.out_byte = rx_rdata;
      default: res.out_byte = 8'd0;
    endcase
  end

  assign res.valid      = out_valid;
  assign res.action     = act_q;
  assign res.rx_count   = rx_count_q;
  assign res.overrun    = ovr_q;
  assign res.host_error = herr_q;

endmodule

[design/i2cts_checker.sv]
// ============================================================================
// i2cts_checker
// Port-level checks on the result channel of the sequencer.
// ============================================================================
module i2cts_checker (
  input logic       clk,
  input logic       rst,
  input logic       res_valid,
  input logic       res_ready,
  input logic [2:0] action,
  input logic [7:0] out_byte,
  input logic       overrun,
  input logic       host_error
);
  import i2cts_pkg::*;

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable({action, out_byte, overrun, host_error}))
    else $error("result changed while stalled");

  // Only a transmit or a host reply carries a byte.
  a_byte: assert property (@(posedge clk) disable iff (rst)
    res_valid && out_byte != 8'd0 |-> action == ACT_TRANSMIT || action == ACT_HOST)
    else $error("byte on an action that carries none");

  // A dropped receive byte is still acknowledged.
  a_ovr: assert property (@(posedge clk) disable iff (rst)
    res_valid && overrun |-> action == ACT_ACK)
    else $error("overrun without acknowledge");

  // Host errors come only from push or pop, and a failed pop returns zero.
  a_herr: assert property (@(posedge clk) disable iff (rst)
    res_valid && host_error |-> (action == ACT_NONE || action == ACT_HOST) &&
                                out_byte == 8'd0)
    else $error("host error on a bus action");

endmodule

bind i2c_target_byte_sequencer i2cts_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .action     (res.action),
  .out_byte   (res.out_byte),
  .overrun    (res.overrun),
  .host_error (res.host_error)
);
